FILE: rtl/mcspg_pkg.sv
// Package for the multi-channel servo pulse generator.
// Shared widths, codes, request/result structs and the start-length helper.
// No dependencies.
`default_nettype none

package mcspg_pkg;

    // Number of servo channels (1 to 8)
    localparam int CHANNELS = 3;

    // Field widths
    localparam int TICK_W  = 28;
    localparam int FRAME_W = 32;
    localparam int POS_W   = 11;
    localparam int CH_W    = 3;
    localparam int CMD_W   = 2;
    localparam int PINS_W  = 3;
    localparam int CIDX_W  = 3;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // Register reset values
    localparam logic [TICK_W-1:0] RST_DELAY    = 28'd250000000;
    localparam logic [TICK_W-1:0] RST_STAGGER  = 28'd524800;
    localparam logic [TICK_W-1:0] RST_INTERVAL = 28'd2500000;
    localparam logic [TICK_W-1:0] RST_MIN      = 28'd112500;
    localparam logic [TICK_W-1:0] RST_CENTER   = 28'd187500;
    localparam logic [TICK_W-1:0] RST_MAX      = 28'd262400;

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_RAW  = 2'd1,
        CMD_NORM = 2'd2
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        REG_START_DELAY    = 3'd0,
        REG_START_STAGGER  = 3'd1,
        REG_FRAME_INTERVAL = 3'd2,
        REG_PULSE_MIN      = 3'd3,
        REG_PULSE_CENTER   = 3'd4,
        REG_PULSE_MAX      = 3'd5
    } cfg_reg_t;

    // Channel phases
    typedef enum logic [1:0] {
        PH_PULSE = 2'd0,
        PH_WAIT  = 2'd1,
        PH_START = 2'd2
    } phase_t;

    // Incoming request
    typedef struct packed {
        cmd_t              cmd;
        logic [CH_W-1:0]   ch;
        logic [POS_W-1:0]  position;
    } req_t;

    // Request leaving the target pipeline, ready for execution
    typedef struct packed {
        logic              valid;
        cmd_t              cmd;
        logic [CH_W-1:0]   ch;
        logic [TICK_W-1:0] target;
    } tgt_t;

    // Start length of a channel: delay + stagger * index, saturated
    function automatic logic [TICK_W-1:0] start_len(
        input logic [TICK_W-1:0] delay,
        input logic [TICK_W-1:0] stagger,
        input logic [CH_W-1:0]   idx
    );
        logic [TICK_W+CH_W:0] sum;
        sum = (TICK_W+CH_W+1)'(delay) + (TICK_W+CH_W+1)'(stagger) * (TICK_W+CH_W+1)'(idx);
        if (sum > (TICK_W+CH_W+1)'(TICK_MAX))
            return TICK_MAX;
        return sum[TICK_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mcspg_target.sv
// Target-width pipeline: raw and normalized position to pulse width.
// Normalized floor division by 1000 uses a split reciprocal multiply.
// Depends on mcspg_pkg.
`default_nettype none

module mcspg_target (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           adv,
    input  wire logic                           in_valid,
    input  wire mcspg_pkg::req_t                in_req,
    input  wire logic [mcspg_pkg::TICK_W-1:0]   pulse_min,
    input  wire logic [mcspg_pkg::TICK_W-1:0]   pulse_center,
    input  wire logic [mcspg_pkg::TICK_W-1:0]   pulse_max,
    output mcspg_pkg::tgt_t                     out
);

    // floor(2^38 / 1000); error of the estimate is at most one
    localparam logic [28:0] RECIP = 29'((64'd1 << 38) / 64'd1000);

    typedef struct packed {
        mcspg_pkg::cmd_t                 cmd;
        logic [mcspg_pkg::CH_W-1:0]      ch;
        logic [mcspg_pkg::TICK_W-1:0]    raw_t;
        logic                            lo;
        logic                            hi;
        logic                            neg;
    } ctl_t;

    // Stage valids
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // Stage payloads
    mcspg_pkg::req_t                 req0_reg;
    ctl_t                            ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    logic [36:0]                     a1_reg;
    logic [37:0]                     x2_reg, x3_reg, x4_reg;
    logic [47:0]                     ph3_reg, pl3_reg;
    logic [28:0]                     qe4_reg, q5_reg;
    mcspg_pkg::tgt_t                 out_reg;

    // Stage 0 logic: offset, raw target, magnitude product
    logic signed [11:0]              d;
    logic [11:0]                     neg_d;
    logic [10:0]                     abs_d;
    logic signed [30:0]              raw_w;
    logic signed [28:0]              rng;
    logic [28:0]                     neg_rng;
    logic [27:0]                     abs_r;
    logic [38:0]                     prod;
    ctl_t                            ctl0;

    always_comb
    begin
        d       = $signed({1'b0, req0_reg.position}) - 12'sd1024;
        neg_d   = -d;
        abs_d   = d[11] ? neg_d[10:0] : d[10:0];
        raw_w   = 31'(d) * 31'sd60 + $signed({3'b0, pulse_center});
        rng     = $signed({1'b0, pulse_max}) - $signed({1'b0, pulse_min});
        neg_rng = -rng;
        abs_r   = rng[28] ? neg_rng[27:0] : rng[27:0];
        prod    = 39'(abs_d) * 39'(abs_r);

        ctl0.cmd = req0_reg.cmd;
        ctl0.ch  = req0_reg.ch;
        if (raw_w <= $signed({3'b0, pulse_min}))
            ctl0.raw_t = pulse_min;
        else if (raw_w >= $signed({3'b0, pulse_max}))
            ctl0.raw_t = pulse_max;
        else
            ctl0.raw_t = raw_w[27:0];
        ctl0.lo  = (d <= -12'sd500);
        ctl0.hi  = (d >= 12'sd500);
        ctl0.neg = d[11] ^ rng[28];
    end

    // Stage 1: round toward minus infinity for negative products
    logic [37:0] x1;
    assign x1 = {1'b0, a1_reg} + (ctl1_reg.neg ? 38'd999 : 38'd0);

    // Stage 2: partial products of the reciprocal
    logic [47:0] ph2, pl2;
    assign ph2 = 48'(x2_reg[37:19]) * 48'(RECIP);
    assign pl2 = 48'(x2_reg[18:0]) * 48'(RECIP);

    // Stage 3: sum and scale to the quotient estimate
    logic [66:0] sum3;
    assign sum3 = {ph3_reg, 19'b0} + 67'(pl3_reg);

    // Stage 4: one correction step
    logic [38:0] rem4;
    logic [28:0] q4;
    always_comb
    begin
        rem4 = 39'(x4_reg) - 39'(qe4_reg) * 39'd1000;
        q4   = qe4_reg + ((rem4 >= 39'd1000) ? 29'd1 : 29'd0);
    end

    // Stage 5: apply sign, clamp and select the final target
    logic signed [30:0]              norm_w;
    logic [mcspg_pkg::TICK_W-1:0]    norm_t;
    mcspg_pkg::tgt_t                 out_next;
    always_comb
    begin
        norm_w = ctl5_reg.neg ? $signed({3'b0, pulse_center}) - $signed({2'b0, q5_reg})
                              : $signed({3'b0, pulse_center}) + $signed({2'b0, q5_reg});
        if (ctl5_reg.lo)
            norm_t = pulse_min;
        else if (ctl5_reg.hi)
            norm_t = pulse_max;
        else if (norm_w < 31'sd0)
            norm_t = '0;
        else if (norm_w > $signed({3'b0, mcspg_pkg::TICK_MAX}))
            norm_t = mcspg_pkg::TICK_MAX;
        else
            norm_t = norm_w[27:0];

        out_next.valid  = v5_reg;
        out_next.cmd    = ctl5_reg.cmd;
        out_next.ch     = ctl5_reg.ch;
        out_next.target = (ctl5_reg.cmd == mcspg_pkg::CMD_RAW) ? ctl5_reg.raw_t : norm_t;
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Payload chain
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            req0_reg <= in_req;
            ctl1_reg <= ctl0;
            a1_reg   <= prod[36:0];
            ctl2_reg <= ctl1_reg;
            x2_reg   <= x1;
            ctl3_reg <= ctl2_reg;
            x3_reg   <= x2_reg;
            ph3_reg  <= ph2;
            pl3_reg  <= pl2;
            ctl4_reg <= ctl3_reg;
            x4_reg   <= x3_reg;
            qe4_reg  <= sum3[66:38];
            ctl5_reg <= ctl4_reg;
            q5_reg   <= q4;
            out_reg  <= out_next;
        end
    end

    always_comb
    begin
        out       = out_reg;
        out.valid = v6_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/multi_channel_servo_pulse_generator_unit.sv
// Top level of the multi-channel servo pulse generator.
// Holds configuration, channel timers, frame counter and the result register.
// Depends on mcspg_pkg and mcspg_target.
`default_nettype none

// One request enters per clock unless backpressure stalls it, and one result
// leaves per request, in order. A request passes eight registers: seven stages
// of the target pipeline (the reciprocal multiply that divides the normalized
// position product by 1000), the first loaded on the accepting edge, plus the
// result register. Ticks and set commands share that path, so the timers and
// target widths are updated in request order. The output register decouples
// the sides; backpressure on the master side stalls the whole pipeline.
// Configuration writes are taken at any time but are meant for an idle block;
// writing the start delay or stagger reloads every channel still waiting for
// its first frame. No clearing pass follows reset.

module multi_channel_servo_pulse_generator_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Request stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [15:0]                      s_tdata,   // [2:0] channel, [13:3] position
    input  wire logic [mcspg_pkg::CMD_W-1:0]      s_tuser,   // [1:0] command
    // Result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [63:0]                           m_tdata,   // [2:0] pin_levels,
                                                             // [3] frame_start,
                                                             // [35:4] frame_count,
                                                             // [63:36] selected_width
    // Configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mcspg_pkg::CIDX_W-1:0]     cfg_index,
    input  wire logic [mcspg_pkg::TICK_W-1:0]     cfg_data
);

    localparam int CH = mcspg_pkg::CHANNELS;

    // Configuration registers
    logic [mcspg_pkg::TICK_W-1:0] start_delay_reg, start_stagger_reg, frame_interval_reg;
    logic [mcspg_pkg::TICK_W-1:0] pulse_min_reg, pulse_center_reg, pulse_max_reg;

    // Channel state
    mcspg_pkg::phase_t            phase_reg   [CH];
    mcspg_pkg::phase_t            phase_next  [CH];
    logic [mcspg_pkg::TICK_W-1:0] count_reg   [CH];
    logic [mcspg_pkg::TICK_W-1:0] count_next  [CH];
    logic [mcspg_pkg::TICK_W-1:0] target_reg  [CH];
    logic [mcspg_pkg::TICK_W-1:0] target_next [CH];
    logic [mcspg_pkg::TICK_W-1:0] latched_reg [CH];
    logic [mcspg_pkg::TICK_W-1:0] latched_next[CH];
    logic [mcspg_pkg::FRAME_W-1:0] frames_reg, frames_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;

    // Pipeline control
    logic            adv, fire, tick_hit, set_hit, ch_ok, cfg_we, reload, frame_hit;
    mcspg_pkg::req_t in_req;
    mcspg_pkg::tgt_t item;
    logic [mcspg_pkg::TICK_W-1:0] new_delay, new_stagger;

    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;

    assign in_req.cmd      = mcspg_pkg::cmd_t'(s_tuser);
    assign in_req.ch       = s_tdata[2:0];
    assign in_req.position = s_tdata[13:3];

    mcspg_target u_target (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (s_tvalid),
        .in_req       (in_req),
        .pulse_min    (pulse_min_reg),
        .pulse_center (pulse_center_reg),
        .pulse_max    (pulse_max_reg),
        .out          (item)
    );

    assign fire     = adv && item.valid;
    assign ch_ok    = ({1'b0, item.ch} < 4'(CH));
    assign tick_hit = fire && (item.cmd == mcspg_pkg::CMD_TICK);
    assign set_hit  = fire && ch_ok &&
                      ((item.cmd == mcspg_pkg::CMD_RAW) || (item.cmd == mcspg_pkg::CMD_NORM));

    // Start-length reload uses the value being written
    assign new_delay   = (cfg_we && cfg_index == mcspg_pkg::REG_START_DELAY)
                         ? cfg_data : start_delay_reg;
    assign new_stagger = (cfg_we && cfg_index == mcspg_pkg::REG_START_STAGGER)
                         ? cfg_data : start_stagger_reg;
    assign reload      = cfg_we && ((cfg_index == mcspg_pkg::REG_START_DELAY) ||
                                    (cfg_index == mcspg_pkg::REG_START_STAGGER));

    // Channel timers and target updates
    always_comb
    begin
        frame_hit = 1'b0;
        for (int c = 0; c < CH; c++)
        begin
            phase_next[c]   = phase_reg[c];
            count_next[c]   = count_reg[c];
            target_next[c]  = target_reg[c];
            latched_next[c] = latched_reg[c];
            if (tick_hit)
            begin
                if (count_reg[c] > 28'd1)
                    count_next[c] = count_reg[c] - 28'd1;
                else if (phase_reg[c] == mcspg_pkg::PH_WAIT)
                begin
                    // pulse start latches the target
                    latched_next[c] = target_reg[c];
                    count_next[c]   = target_reg[c];
                    phase_next[c]   = mcspg_pkg::PH_PULSE;
                end
                else
                begin
                    // wait start: rest of the frame, at least one tick
                    count_next[c] = (frame_interval_reg > latched_reg[c])
                                    ? frame_interval_reg - latched_reg[c] : '0;
                    phase_next[c] = mcspg_pkg::PH_WAIT;
                    if (c == 0)
                        frame_hit = 1'b1;
                end
            end
            if (set_hit && item.ch == 3'(c))
                target_next[c] = item.target;
            if (reload && phase_reg[c] == mcspg_pkg::PH_START)
                count_next[c] = mcspg_pkg::start_len(new_delay, new_stagger, 3'(c));
        end
        frames_next = frames_reg + (frame_hit ? 32'd1 : 32'd0);
    end

    // Result assembly
    logic [mcspg_pkg::PINS_W-1:0] pins;
    logic [mcspg_pkg::TICK_W-1:0] sel_width;
    always_comb
    begin
        pins      = '0;
        sel_width = '0;
        for (int c = 0; c < CH; c++)
        begin
            if (c < mcspg_pkg::PINS_W && phase_next[c] == mcspg_pkg::PH_PULSE)
                pins[c] = 1'b1;
            if (ch_ok && item.ch == 3'(c))
                sel_width = target_next[c];
        end
        out_data_next = {sel_width, frames_next, frame_hit, pins};
        if (fire)
            out_valid_next = 1'b1;
        else if (adv)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delay_reg    <= mcspg_pkg::RST_DELAY;
            start_stagger_reg  <= mcspg_pkg::RST_STAGGER;
            frame_interval_reg <= mcspg_pkg::RST_INTERVAL;
            pulse_min_reg      <= mcspg_pkg::RST_MIN;
            pulse_center_reg   <= mcspg_pkg::RST_CENTER;
            pulse_max_reg      <= mcspg_pkg::RST_MAX;
        end
        else if (cfg_we)
        begin
            unique case (mcspg_pkg::cfg_reg_t'(cfg_index))
                mcspg_pkg::REG_START_DELAY:    start_delay_reg    <= cfg_data;
                mcspg_pkg::REG_START_STAGGER:  start_stagger_reg  <= cfg_data;
                mcspg_pkg::REG_FRAME_INTERVAL: frame_interval_reg <= cfg_data;
                mcspg_pkg::REG_PULSE_MIN:      pulse_min_reg      <= cfg_data;
                mcspg_pkg::REG_PULSE_CENTER:   pulse_center_reg   <= cfg_data;
                mcspg_pkg::REG_PULSE_MAX:      pulse_max_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Channel state and frame counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CH; c++)
            begin
                phase_reg[c]   <= mcspg_pkg::PH_START;
                count_reg[c]   <= mcspg_pkg::start_len(mcspg_pkg::RST_DELAY,
                                                       mcspg_pkg::RST_STAGGER, 3'(c));
                target_reg[c]  <= mcspg_pkg::RST_CENTER;
                latched_reg[c] <= '0;
            end
            frames_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int c = 0; c < CH; c++)
            begin
                phase_reg[c]   <= phase_next[c];
                count_reg[c]   <= count_next[c];
                target_reg[c]  <= target_next[c];
                latched_reg[c] <= latched_next[c];
            end
            frames_reg    <= frames_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
